// File: rtl/core/gn2_pkg.sv
// Shared types and constants for the 2D gradient noise block.
// No dependencies; imported by every module of the block.
package gn2_pkg;

    // Default parameter values; TABLE_SIZE must be a power of two
    localparam int TABLE_SIZE_DEF = 256;
    localparam int FRAC_BITS_DEF  = 8;

    // Fixed field widths
    localparam int COORD_W = 16;
    localparam int TAB_W   = 8;     // table index and permutation entry
    localparam int GRAD_W  = 16;
    localparam int NOISE_W = 16;

    // Pipeline depths
    localparam int LOOKUP_LAT = 3;  // perm level A, perm level B, gradient read
    localparam int DOT_LAT    = 2;  // products, then corner sums
    localparam int LERP_LAT   = 4;
    localparam int MATH_LAT   = DOT_LAT + 2 * LERP_LAT + 2;

    // Command codes
    localparam logic [1:0] FN_EVAL = 2'd0;
    localparam logic [1:0] FN_PERM = 2'd1;
    localparam logic [1:0] FN_GRAD = 2'd2;

    typedef struct packed {
        logic              perm_we;
        logic              grad_we;
        logic [TAB_W-1:0]  index;
        logic [TAB_W-1:0]  perm;
        logic [GRAD_W-1:0] grad_x;
        logic [GRAD_W-1:0] grad_y;
    } t_load;

    // Corner order: (x0,y0), (x1,y0), (x0,y1), (x1,y1)
    typedef struct packed {
        logic [3:0][GRAD_W-1:0] gx;
        logic [3:0][GRAD_W-1:0] gy;
    } t_grads;

endpackage

// File: rtl/core/gn2_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Depends on gn2_pkg for default sizes only.
module gn2_ram import gn2_pkg::*; #(
    parameter int WIDTH = TAB_W,
    parameter int DEPTH = TABLE_SIZE_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/core/gn2_lookup.sv
// Table lookup pipeline: two levels of permutation hashing, then gradient read.
// Depends on gn2_pkg and gn2_ram.
module gn2_lookup import gn2_pkg::*; #(
    parameter int TABLE_SIZE = TABLE_SIZE_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_eval,
    input  logic [COORD_W-1:0] i_x_coord,
    input  logic [COORD_W-1:0] i_y_coord,
    input  t_load              i_load,
    output logic               o_grad_valid,
    output t_grads             o_grads
);

    localparam int AW  = $clog2(TABLE_SIZE);
    localparam int GW2 = 2 * GRAD_W;

    function automatic logic [AW-1:0] tab_addr(input logic [TAB_W-1:0] v);
        logic [TAB_W+AW-1:0] e;
        e = {{AW{1'b0}}, v};
        return e[AW-1:0];
    endfunction

    function automatic logic [AW-1:0] cell_of(input logic [COORD_W-1:0] c);
        logic [COORD_W+AW-1:0] e;
        e = {{AW{1'b0}}, c} >> FRAC_BITS;
        return e[AW-1:0];
    endfunction

    logic [AW-1:0]    ix0, iy0, iy1;
    logic [AW-1:0]    r_iy1;
    logic             r_v1, r_v2, r_v3;
    t_load            r_ld1, r_ld2;
    logic [AW-1:0]    a_waddr, b_waddr, g_waddr;
    logic [AW-1:0]    a_raddr [2];
    logic [AW-1:0]    b_raddr [4];
    logic [AW-1:0]    g_raddr [4];
    logic [TAB_W-1:0] a_rdata [2];
    logic [TAB_W-1:0] b_rdata [4];
    logic [GW2-1:0]   g_rdata [4];

    assign ix0 = cell_of(i_x_coord);
    assign iy0 = cell_of(i_y_coord);
    assign iy1 = r_iy1 + AW'(1);

    assign a_raddr[0] = ix0;
    assign a_raddr[1] = ix0 + AW'(1);

    // Hash sums wrap at the table size
    assign b_raddr[0] = r_iy1 + tab_addr(a_rdata[0]);
    assign b_raddr[1] = r_iy1 + tab_addr(a_rdata[1]);
    assign b_raddr[2] = iy1 + tab_addr(a_rdata[0]);
    assign b_raddr[3] = iy1 + tab_addr(a_rdata[1]);

    // Each replica is written at the same stage it is read, so every beat
    // sees exactly the writes of the beats before it.
    assign a_waddr = tab_addr(i_load.index);
    assign b_waddr = tab_addr(r_ld1.index);
    assign g_waddr = tab_addr(r_ld2.index);

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            g_raddr[k]    = tab_addr(b_rdata[k]);
            o_grads.gx[k] = g_rdata[k][GW2-1:GRAD_W];
            o_grads.gy[k] = g_rdata[k][GRAD_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1  <= 1'b0;
            r_v2  <= 1'b0;
            r_v3  <= 1'b0;
            r_ld1 <= '0;
            r_ld2 <= '0;
        end else begin
            r_v1  <= i_eval;
            r_v2  <= r_v1;
            r_v3  <= r_v2;
            r_ld1 <= i_load;
            r_ld2 <= r_ld1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_iy1 <= iy0;
    end

    for (genvar g = 0; g < 2; g++) begin : g_perm_a
        gn2_ram #(.WIDTH(TAB_W), .DEPTH(TABLE_SIZE)) u_ram (
            .i_clk   (i_clk),
            .i_we    (i_load.perm_we),
            .i_waddr (a_waddr),
            .i_wdata (i_load.perm),
            .i_raddr (a_raddr[g]),
            .o_rdata (a_rdata[g])
        );
    end

    for (genvar g = 0; g < 4; g++) begin : g_perm_b
        gn2_ram #(.WIDTH(TAB_W), .DEPTH(TABLE_SIZE)) u_ram (
            .i_clk   (i_clk),
            .i_we    (r_ld1.perm_we),
            .i_waddr (b_waddr),
            .i_wdata (r_ld1.perm),
            .i_raddr (b_raddr[g]),
            .o_rdata (b_rdata[g])
        );
    end

    for (genvar g = 0; g < 4; g++) begin : g_grad
        gn2_ram #(.WIDTH(GW2), .DEPTH(TABLE_SIZE)) u_ram (
            .i_clk   (i_clk),
            .i_we    (r_ld2.grad_we),
            .i_waddr (g_waddr),
            .i_wdata ({r_ld2.grad_x, r_ld2.grad_y}),
            .i_raddr (g_raddr[g]),
            .o_rdata (g_rdata[g])
        );
    end

    assign o_grad_valid = r_v3;

endmodule

// File: rtl/core/gn2_lerp.sv
// One pipelined blend step: v = a - round(w * (a - b) / 2^F), round half up.
// Depends on gn2_pkg for defaults.
module gn2_lerp import gn2_pkg::*; #(
    parameter int A_W       = GRAD_W + FRAC_BITS_DEF + 2,
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic signed [A_W-1:0] i_a,
    input  logic signed [A_W-1:0] i_b,
    input  logic [FRAC_BITS:0]    i_w,
    output logic signed [A_W:0]   o_v
);

    localparam int M_W = A_W + FRAC_BITS + 3;
    localparam logic signed [M_W-1:0] HALF = M_W'(1) << (FRAC_BITS - 1);

    logic signed [A_W-1:0] r_a1, r_a2, r_a3;
    logic signed [A_W:0]   r_d;
    logic [FRAC_BITS:0]    r_w1;
    logic signed [M_W-1:0] r_m;
    logic signed [M_W-1:0] m_rnd;
    logic signed [A_W:0]   r_r;
    logic signed [A_W:0]   r_v;

    assign m_rnd = (r_m + HALF) >>> FRAC_BITS;

    always_ff @(posedge i_clk) begin
        r_a1 <= i_a;
        r_d  <= i_a - i_b;
        r_w1 <= i_w;
        r_a2 <= r_a1;
        r_m  <= $signed({1'b0, r_w1}) * r_d;
        r_a3 <= r_a2;
        r_r  <= m_rnd[A_W:0];
        r_v  <= r_a3 - r_r;
    end

    assign o_v = r_v;

endmodule

// File: rtl/core/gn2_math.sv
// Arithmetic datapath: smoothstep weights, corner dot products, blends, saturation.
// Depends on gn2_pkg and gn2_lerp.
module gn2_math import gn2_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic [FRAC_BITS-1:0]      i_tx,
    input  logic [FRAC_BITS-1:0]      i_ty,
    input  logic                      i_grad_valid,
    input  t_grads                    i_grads,
    output logic                      o_strobe,
    output logic signed [NOISE_W-1:0] o_noise
);

    localparam int F      = FRAC_BITS;
    localparam int D_W    = F + 1;
    localparam int P_W    = GRAD_W + D_W;
    localparam int DOT_W  = P_W + 1;
    localparam int W_W    = F + 1;
    localparam int SQ_W   = 2 * F;
    localparam int NUM_W  = 3 * F + 2;
    localparam int XV_W   = DOT_W + 1;
    localparam int YV_W   = XV_W + 1;
    localparam int FIN_W  = NOISE_W + 5;
    localparam int WY_DLY = DOT_LAT + LERP_LAT;

    localparam logic [F+1:0]            THREE_ONE = (F + 2)'(3) << F;
    localparam logic [NUM_W-1:0]        W_HALF    = NUM_W'(1) << (2 * F - 1);
    localparam logic signed [YV_W:0]    F_HALF    = (YV_W + 1)'(1) << (F - 1);
    localparam logic signed [FIN_W-1:0] SAT_HI    = FIN_W'(32767);
    localparam logic signed [FIN_W-1:0] SAT_LO    = FIN_W'(-32768);

    // Axis 0 is x, axis 1 is y
    logic [F-1:0]              t_in    [2];
    logic [F-1:0]              r_t1    [2];
    logic [F-1:0]              r_t2    [2];
    logic [F-1:0]              r_t3    [2];
    logic [SQ_W-1:0]           r_sq    [2];
    logic [F+1:0]              k_fac   [2];
    logic [NUM_W-1:0]          r_num   [2];
    logic [NUM_W-1:0]          w_sum   [2];
    logic [W_W-1:0]            r_w     [2];
    logic [W_W-1:0]            r_wx_d  [DOT_LAT];
    logic [W_W-1:0]            r_wy_d  [WY_DLY];
    logic signed [D_W-1:0]     dx      [2];
    logic signed [D_W-1:0]     dy      [2];
    logic signed [P_W-1:0]     r_px    [4];
    logic signed [P_W-1:0]     r_py    [4];
    logic signed [DOT_W-1:0]   r_dot   [4];
    logic signed [XV_W-1:0]    v0, v1;
    logic signed [YV_W-1:0]    yv;
    logic signed [YV_W:0]      f_sum, f_shr;
    logic signed [FIN_W-1:0]   r_fin;
    logic signed [NOISE_W-1:0] n_noise, r_noise;
    logic [MATH_LAT-1:0]       r_vld;

    assign t_in[0] = i_tx;
    assign t_in[1] = i_ty;

    // Far corner offset t - 1 is just t with the sign bit set
    assign dx[0] = $signed({1'b0, r_t3[0]});
    assign dx[1] = $signed({1'b1, r_t3[0]});
    assign dy[0] = $signed({1'b0, r_t3[1]});
    assign dy[1] = $signed({1'b1, r_t3[1]});

    always_comb begin
        for (int a = 0; a < 2; a++) begin
            k_fac[a] = THREE_ONE - {1'b0, r_t1[a], 1'b0};
            w_sum[a] = r_num[a] + W_HALF;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int a = 0; a < 2; a++) begin
            r_t1[a]  <= t_in[a];
            r_sq[a]  <= t_in[a] * t_in[a];
            r_t2[a]  <= r_t1[a];
            r_num[a] <= r_sq[a] * k_fac[a];
            r_t3[a]  <= r_t2[a];
            r_w[a]   <= w_sum[a][2*F +: W_W];
        end
        for (int k = 0; k < 4; k++) begin
            r_px[k]  <= $signed(i_grads.gx[k]) * dx[k % 2];
            r_py[k]  <= $signed(i_grads.gy[k]) * dy[k / 2];
            r_dot[k] <= r_px[k] + r_py[k];
        end
        r_wx_d[0] <= r_w[0];
        for (int k = 1; k < DOT_LAT; k++) begin
            r_wx_d[k] <= r_wx_d[k-1];
        end
        r_wy_d[0] <= r_w[1];
        for (int k = 1; k < WY_DLY; k++) begin
            r_wy_d[k] <= r_wy_d[k-1];
        end
        r_fin   <= f_shr[FIN_W-1:0];
        r_noise <= n_noise;
    end

    gn2_lerp #(.A_W(DOT_W), .FRAC_BITS(F)) u_lerp_x0 (
        .i_clk (i_clk),
        .i_a   (r_dot[0]),
        .i_b   (r_dot[1]),
        .i_w   (r_wx_d[DOT_LAT-1]),
        .o_v   (v0)
    );

    gn2_lerp #(.A_W(DOT_W), .FRAC_BITS(F)) u_lerp_x1 (
        .i_clk (i_clk),
        .i_a   (r_dot[2]),
        .i_b   (r_dot[3]),
        .i_w   (r_wx_d[DOT_LAT-1]),
        .o_v   (v1)
    );

    gn2_lerp #(.A_W(XV_W), .FRAC_BITS(F)) u_lerp_y (
        .i_clk (i_clk),
        .i_a   (v0),
        .i_b   (v1),
        .i_w   (r_wy_d[WY_DLY-1]),
        .o_v   (yv)
    );

    assign f_sum = yv + F_HALF;
    assign f_shr = f_sum >>> F;

    always_comb begin
        priority if (r_fin > SAT_HI) begin
            n_noise = SAT_HI[NOISE_W-1:0];
        end else if (r_fin < SAT_LO) begin
            n_noise = SAT_LO[NOISE_W-1:0];
        end else begin
            n_noise = r_fin[NOISE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[MATH_LAT-2:0], i_grad_valid};
        end
    end

    assign o_strobe = r_vld[MATH_LAT-1];
    assign o_noise  = r_noise;

endmodule

// File: rtl/core/gradient_noise_2d_top.sv
// Top level of the 2D gradient noise block.
// Depends on gn2_pkg, gn2_lookup and gn2_math.

// Takes one command every clock: busy is never raised, so a command is taken
// whenever start is high. An evaluate command gives its noise sample on
// o_noise_value, with o_strobe high for that one cycle, once it has passed the
// table lookup and arithmetic pipelines; samples come out in command order and
// must be captured when they appear. Table writes (func 1 and 2) give no output
// and apply to every evaluate taken after them, including the very next cycle;
// func 3 does nothing. The one-per-clock rate comes from each lookup level
// having its own replica of the table it reads (two and four permutation
// copies, four gradient copies), each written at the level that reads it.
// Tables hold no reset value and need no clearing pass; entries must be
// written before they are used. TABLE_SIZE must be a power of two.
module gradient_noise_2d_top import gn2_pkg::*; #(
    parameter int TABLE_SIZE = TABLE_SIZE_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic [1:0]                i_func,
    input  logic [COORD_W-1:0]        i_x_coord,
    input  logic [COORD_W-1:0]        i_y_coord,
    input  logic [TAB_W-1:0]          i_table_index,
    input  logic [TAB_W-1:0]          i_perm_value,
    input  logic signed [GRAD_W-1:0]  i_grad_x_value,
    input  logic signed [GRAD_W-1:0]  i_grad_y_value,
    output logic                      o_strobe,
    output logic signed [NOISE_W-1:0] o_noise_value
);

    localparam int PIPE_LAT = LOOKUP_LAT + MATH_LAT;

    logic   w_accept;
    logic   w_eval;
    t_load  w_load;
    logic   w_grad_valid;
    t_grads w_grads;

    assign busy     = 1'b0;
    assign w_accept = start && !busy;
    assign w_eval   = w_accept && (i_func == FN_EVAL);

    always_comb begin
        w_load.perm_we = w_accept && (i_func == FN_PERM);
        w_load.grad_we = w_accept && (i_func == FN_GRAD);
        w_load.index   = i_table_index;
        w_load.perm    = i_perm_value;
        w_load.grad_x  = i_grad_x_value;
        w_load.grad_y  = i_grad_y_value;
    end

    gn2_lookup #(.TABLE_SIZE(TABLE_SIZE), .FRAC_BITS(FRAC_BITS)) u_lookup (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_eval       (w_eval),
        .i_x_coord    (i_x_coord),
        .i_y_coord    (i_y_coord),
        .i_load       (w_load),
        .o_grad_valid (w_grad_valid),
        .o_grads      (w_grads)
    );

    gn2_math #(.FRAC_BITS(FRAC_BITS)) u_math (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_tx         (i_x_coord[FRAC_BITS-1:0]),
        .i_ty         (i_y_coord[FRAC_BITS-1:0]),
        .i_grad_valid (w_grad_valid),
        .i_grads      (w_grads),
        .o_strobe     (o_strobe),
        .o_noise      (o_noise_value)
    );

    // Every strobe traces back to an evaluate beat a fixed latency earlier
    a_strobe_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(w_eval, PIPE_LAT))
        else $error("noise strobe without a matching evaluate beat");

    // Every evaluate beat yields exactly one strobe after the pipeline latency
    a_eval_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_eval |-> ##PIPE_LAT o_strobe)
        else $error("evaluate beat lost in the pipeline");

    // Gradients leave the lookup stage aligned to the evaluate beat
    a_lookup_align: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_grad_valid |-> $past(w_eval, LOOKUP_LAT))
        else $error("gradient data out of step with evaluate beat");

endmodule
